FILE: src/ramr_pkg.sv
// Package for the rational add/multiply/reduce block.
// Holds the width constants, the command codes and the sequencer state type.
// No dependencies.
package ramr_pkg;
  localparam int OPERAND_BITS = 15;
  localparam int OUT_BITS     = 2 * OPERAND_BITS + 1;
  localparam int CNT_BITS     = $clog2(OUT_BITS + 1);

  typedef enum logic [1:0] {
    CMD_MAKE = 2'd0,
    CMD_ADD  = 2'd1,
    CMD_MUL  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_GCD_START,
    ST_GCD_DIV,
    ST_GCD_STEP,
    ST_DIVN_START,
    ST_DIVN,
    ST_DIVD_START,
    ST_DIVD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage

FILE: src/rational_add_mul_reduce_top.sv
// Top level of the rational add/multiply/reduce block.
// Depends on ramr_pkg and ramr_div.
//
// Usage:
//   Input channel (valid/ready): cmd selects make (from a), add a+b or
//   multiply a*b on two 15-bit fractions with validity flags. One transfer
//   starts one computation; ready is low until the result has been taken.
//   Output channel (valid/ready): res_num/res_den/res_valid, the result
//   reduced by the GCD (a zero numerator leaves the denominator as is).
//   Invalid add/mul operands, a zero denominator or cmd 3 give 0/0, invalid.
// Sequencing:
//   Products are built by up to three passes through one 15x15 multiplier
//   (states MUL1 and MUL2 for multiply, MUL3 as well for add). GCD uses
//   Euclid with the shared restoring divider, one division per remainder
//   step (up to ~45 steps for 31-bit values), then two more divisions for
//   numerator and denominator. One item at a time.
// Reset: sync active-high rst returns the sequencer to idle, output empty.
// Stall: the result holds on the ports until ready; no new input meanwhile.
module rational_add_mul_reduce_top
  import ramr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              cmd,
  input  logic [OPERAND_BITS-1:0] a_num,
  input  logic [OPERAND_BITS-1:0] a_den,
  input  logic                    a_valid,
  input  logic [OPERAND_BITS-1:0] b_num,
  input  logic [OPERAND_BITS-1:0] b_den,
  input  logic                    b_valid,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [OUT_BITS-1:0]     res_num,
  output logic [OUT_BITS-1:0]     res_den,
  output logic                    res_valid
);
  state_t state, state_next;

  // Operand latches
  logic [OPERAND_BITS-1:0] an, ad, bn, bd;
  cmd_t                    op;
  // Products and working values
  logic [OUT_BITS-1:0] num;     // unreduced numerator
  logic [OUT_BITS-1:0] den;     // unreduced denominator
  logic [OUT_BITS-1:0] gx, gy;  // Euclid pair
  // Shared multiplier
  logic [OPERAND_BITS-1:0]   mul_a, mul_b;
  logic [2*OPERAND_BITS-1:0] mul_p;
  // Divider
  logic                div_start;
  logic [OUT_BITS-1:0] div_n, div_d, div_q, div_r;
  div_ctl_t            dctl;

  logic ok;

  assign mul_p = mul_a * mul_b;

  ramr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .ctl      (dctl),
    .quotient (div_q),
    .remainder(div_r)
  );

  assign in_ready = (state == ST_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_MUL1;
      end
      ST_MUL1: begin
        if (!ok) state_next = ST_DONE;
        else if (op == CMD_MAKE) state_next = ST_GCD_START;
        else state_next = ST_MUL2;
      end
      ST_MUL2: state_next = (op == CMD_ADD) ? ST_MUL3 : ST_GCD_START;
      ST_MUL3: state_next = ST_GCD_START;
      ST_GCD_START: begin
        if (num == '0 || den == '0) state_next = ST_DONE;
        else state_next = ST_GCD_DIV;
      end
      ST_GCD_DIV: begin
        if (dctl.done) state_next = ST_GCD_STEP;
      end
      ST_GCD_STEP: begin
        if (div_r == '0) state_next = ST_DIVN_START;
        else state_next = ST_GCD_DIV;
      end
      ST_DIVN_START: state_next = ST_DIVN;
      ST_DIVN: begin
        if (dctl.done) state_next = ST_DIVD_START;
      end
      ST_DIVD_START: state_next = ST_DIVD;
      ST_DIVD: begin
        if (dctl.done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs and datapath control
  always_comb begin
    mul_a     = an;
    mul_b     = bd;
    div_start = 1'b0;
    div_n     = gx;
    div_d     = gy;
    unique case (state)
      ST_MUL1: begin
        mul_a = an;
        mul_b = (op == CMD_MUL) ? bn : bd;
      end
      ST_MUL2: begin
        mul_a = ad;
        mul_b = bd;
      end
      ST_MUL3: begin
        mul_a = ad;
        mul_b = bn;
      end
      // first remainder step starts on the raw pair
      ST_GCD_START: begin
        div_start = (num != '0) && (den != '0);
        div_n     = num;
        div_d     = den;
      end
      // next step divides the old divisor by the remainder
      ST_GCD_STEP: begin
        div_start = (div_r != '0);
        div_n     = gy;
        div_d     = div_r;
      end
      ST_DIVN_START: begin
        div_start = 1'b1;
        div_n     = num;
      end
      ST_DIVD_START: begin
        div_start = 1'b1;
        div_n     = den;
      end
      default: ;
    endcase
  end

  assign out_valid = (state == ST_DONE);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          an <= a_num;
          ad <= a_den;
          bn <= b_num;
          bd <= b_den;
          op <= cmd_t'(cmd);
          unique case (cmd_t'(cmd)) inside
            CMD_MAKE: ok <= (a_den != '0);
            CMD_ADD, CMD_MUL: ok <= a_valid && b_valid && (a_den != '0) && (b_den != '0);
            default: ok <= 1'b0;
          endcase
        end
      end
      ST_MUL1: begin
        if (!ok) begin
          res_num <= '0;
          res_den <= '0;
        end
        if (op == CMD_MAKE) begin
          num <= OUT_BITS'(an);
          den <= OUT_BITS'(ad);
        end else begin
          num <= OUT_BITS'(mul_p);
        end
      end
      ST_MUL2: den <= OUT_BITS'(mul_p);
      ST_MUL3: num <= num + OUT_BITS'(mul_p);
      ST_GCD_START: begin
        gx <= num;
        gy <= den;
        res_num   <= num;
        res_den   <= den;
      end
      ST_GCD_STEP: begin
        if (div_r != '0) begin
          gx <= gy;
          gy <= div_r;
        end
      end
      ST_DIVN: if (dctl.done) res_num <= div_q;
      ST_DIVD: if (dctl.done) res_den <= div_q;
      default: ;
    endcase
  end

  // Result valid flag; invalid results read as zero.
  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (state == ST_MUL1) res_valid <= ok;
  end
endmodule

FILE: src/ram_pkg_dummy.sv
// (intentionally none)

FILE: src/ramr_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on ramr_pkg.
module ramr_div
  import ramr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [OUT_BITS-1:0] dividend,
  input  logic [OUT_BITS-1:0] divisor,
  output div_ctl_t            ctl,
  output logic [OUT_BITS-1:0] quotient,
  output logic [OUT_BITS-1:0] remainder
);
  logic [OUT_BITS-1:0] q;
  logic [OUT_BITS-1:0] r;
  logic [OUT_BITS-1:0] d;
  logic [CNT_BITS-1:0] cnt;
  logic                busy;
  logic                done;
  logic [OUT_BITS:0]   trial;
  logic [OUT_BITS:0]   diff;

  assign trial = {r, q[OUT_BITS-1]};
  assign diff  = trial - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(OUT_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      r <= '0;
      d <= divisor;
    end else if (busy) begin
      if (!diff[OUT_BITS]) begin
        r <= diff[OUT_BITS-1:0];
        q <= {q[OUT_BITS-2:0], 1'b1};
      end else begin
        r <= trial[OUT_BITS-1:0];
        q <= {q[OUT_BITS-2:0], 1'b0};
      end
    end
  end

  assign ctl.start = start;
  assign ctl.busy  = busy;
  assign ctl.done  = done;
  assign quotient  = q;
  assign remainder = r;
endmodule

FILE: dv/ramr_checker.sv
// Checker for the rational add/multiply/reduce block: watches both channels,
// predicts each reduced fraction and compares it. Depends on ramr_pkg.
`timescale 1ns / 1ps
module ramr_checker
  import ramr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [1:0]              cmd,
  input  logic [OPERAND_BITS-1:0] a_num,
  input  logic [OPERAND_BITS-1:0] a_den,
  input  logic                    a_valid,
  input  logic [OPERAND_BITS-1:0] b_num,
  input  logic [OPERAND_BITS-1:0] b_den,
  input  logic                    b_valid,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [OUT_BITS-1:0]     res_num,
  input  logic [OUT_BITS-1:0]     res_den,
  input  logic                    res_valid,
  output int                      mismatches,
  output int                      pending
);
  typedef struct packed {
    logic [OUT_BITS-1:0] num;
    logic [OUT_BITS-1:0] den;
    logic                ok;
  } fraction_t;

  fraction_t fractions_due[$];

  function automatic longint unsigned euclid(longint unsigned x, longint unsigned y);
    longint unsigned t;
    if (x == 0 || y == 0) return 1;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic fraction_t reduce_fraction(logic ok, longint unsigned n,
                                                longint unsigned d);
    fraction_t f;
    longint unsigned g;
    f = '0;
    if (!ok) return f;
    g = euclid(n, d);
    f.num = OUT_BITS'(n / g);
    f.den = OUT_BITS'(d / g);
    f.ok  = 1'b1;
    return f;
  endfunction

  function automatic fraction_t predict_fraction();
    longint unsigned an, ad, bn, bd;
    logic av, bv;
    an = a_num; ad = a_den; bn = b_num; bd = b_den;
    // a flagged operand with zero denominator counts as empty
    av = a_valid && ad != 0;
    bv = b_valid && bd != 0;
    case (cmd_t'(cmd))
      CMD_MAKE: return reduce_fraction(ad != 0, an, ad);
      CMD_ADD:  return reduce_fraction(av && bv, an * bd + ad * bn, ad * bd);
      CMD_MUL:  return reduce_fraction(av && bv, an * bn, ad * bd);
      default:  return reduce_fraction(1'b0, 0, 0);
    endcase
  endfunction

  assign pending = fractions_due.size();

  always @(posedge clk) begin
    fraction_t want;
    if (rst) begin
      mismatches <= 0;
    end else begin
      if (in_valid && in_ready) fractions_due.push_back(predict_fraction());
      if (out_valid && out_ready) begin
        if (fractions_due.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result %0d/%0d v%0d", res_num, res_den, res_valid);
          mismatches <= mismatches + 1;
        end else begin
          want = fractions_due.pop_front();
          if (want.num !== res_num || want.den !== res_den || want.ok !== res_valid) begin
            if (mismatches < 10)
              $display("mismatch: want %0d/%0d v%0d got %0d/%0d v%0d",
                       want.num, want.den, want.ok, res_num, res_den, res_valid);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end
endmodule

FILE: dv/tb_rational_add_mul_reduce_top.sv
// Testbench top for rational_add_mul_reduce_top: directed and random
// fractions, bursty sender, stalling receiver. Depends on ramr_pkg, ramr_checker.
`timescale 1ns / 1ps
module tb_rational_add_mul_reduce_top;
  import ramr_pkg::*;

  localparam int N_RANDOM   = 1830;
  localparam int IDLE_LIMIT = 20000; // worst-case result plus long stall

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_ready, out_valid, out_ready = 1'b0;
  logic [1:0] cmd = '0;
  logic [OPERAND_BITS-1:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
  logic a_valid = 1'b0, b_valid = 1'b0;
  logic [OUT_BITS-1:0] res_num, res_den;
  logic res_valid;
  int mismatches, pending;
  int idle_cycles = 0;
  bit hold_off = 1'b0;   // long receiver stall in progress

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rational_add_mul_reduce_top i_dut (.*);

  ramr_checker i_chk (.*);

  // Receiver: stalls on its own pattern; one long hold-off mid-run.
  always @(posedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 99) < 5);
  end

  // Watchdog: cycles with no transfer on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [OPERAND_BITS-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return OPERAND_BITS'($urandom_range(1, 12));
      3: return OPERAND_BITS'($urandom_range(1, 255));
      default: return OPERAND_BITS'($urandom);
    endcase
  endfunction

  // Present one transfer and hold it until accepted.
  task automatic send(logic [1:0] c, logic [OPERAND_BITS-1:0] an, ad,
                      logic av, logic [OPERAND_BITS-1:0] bn, bd, logic bv);
    cmd <= c; a_num <= an; a_den <= ad; a_valid <= av;
    b_num <= bn; b_den <= bd; b_valid <= bv;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    int burst;
    logic [1:0] c;
    bit stall_done;
    stall_done = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners
    send(CMD_MAKE, 15'd4, 15'd6, 1'b0, '0, 15'd1, 1'b0);
    send(CMD_MAKE, 15'd0, 15'd6, 1'b0, '0, 15'd1, 1'b0);     // zero numerator
    send(CMD_MAKE, 15'd5, 15'd0, 1'b1, '0, 15'd1, 1'b1);     // make, zero den
    send(CMD_MAKE, '1, '1, 1'b1, '1, '1, 1'b1);
    send(CMD_ADD, 15'd1, 15'd2, 1'b1, 15'd1, 15'd3, 1'b1);
    send(CMD_ADD, 15'd1, 15'd2, 1'b1, 15'd1, 15'd2, 1'b1);
    send(CMD_ADD, '1, '1, 1'b1, '1, '1, 1'b1);
    send(CMD_ADD, '0, 15'd4, 1'b1, '0, 15'd6, 1'b1);         // zero sum
    send(CMD_ADD, 15'd1, 15'd2, 1'b0, 15'd1, 15'd3, 1'b1);   // a empty
    send(CMD_ADD, 15'd1, 15'd2, 1'b1, 15'd1, 15'd3, 1'b0);   // b empty
    send(CMD_ADD, 15'd1, 15'd0, 1'b1, 15'd1, 15'd3, 1'b1);   // flagged a, zero den
    send(CMD_MUL, 15'd2, 15'd3, 1'b1, 15'd3, 15'd4, 1'b1);
    send(CMD_MUL, '1, '1, 1'b1, '1, 15'd1, 1'b1);
    send(CMD_MUL, '1, 15'd1, 1'b1, '1, 15'd1, 1'b1);
    send(CMD_MUL, '0, 15'd7, 1'b1, 15'd9, 15'd5, 1'b1);      // zero product
    send(CMD_MUL, 15'd3, 15'd5, 1'b1, 15'd2, 15'd0, 1'b1);   // flagged b, zero den
    send(CMD_MUL, 15'd3, 15'd5, 1'b0, 15'd2, 15'd7, 1'b0);
    send(CMD_NONE, 15'd3, 15'd5, 1'b1, 15'd2, 15'd7, 1'b1);  // unused command
    send(CMD_MAKE, 15'h5555, 15'h2aaa, 1'b0, 15'h2aaa, 15'h5555, 1'b0);

    for (int i = 0; i < N_RANDOM; ) begin
      if (i >= N_RANDOM / 2 && !stall_done) begin
        // Long receiver stall while items keep being offered.
        stall_done = 1'b1;
        hold_off = 1'b1;
        fork
          begin
            repeat (3000) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && i < N_RANDOM; k++, i++) begin
        // mostly valid operands with real commands, some noise
        c = ($urandom_range(0, 19) == 0) ? CMD_NONE : 2'($urandom_range(0, 2));
        send(c, pick_value(), pick_value(), $urandom_range(0, 9) != 0,
             pick_value(), pick_value(), $urandom_range(0, 9) != 0);
      end
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 150)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

FILE: sim.f
src/ram_pkg_dummy.sv
src/ramr_pkg.sv
src/ramr_div.sv
src/rational_add_mul_reduce_top.sv
dv/ramr_checker.sv
dv/tb_rational_add_mul_reduce_top.sv
